// File: rtl/aewp_pkg.sv
// ----------------------------------------------------------------------------
// aewp_pkg
// Shared constants, arctangent table and result type for the azimuth /
// elevation block.
// ----------------------------------------------------------------------------
package aewp_pkg;

	localparam int ANG_W         = 32;  // binary angle width, 2^32 = 2pi
	localparam int GUARD_SHIFT   = 24;  // fraction bits added to the CORDIC inputs
	localparam int Q_BITS        = 63;  // quotient bits per division
	localparam int DEL_NUM_SHIFT = 94;  // numerator scale of the elevation partials
	localparam int DUP_SHIFT     = 30;  // numerator scale of d(el)/d(up)
	localparam int TAB_LEN       = 40;

	localparam logic [ANG_W-1:0] ANG_HALF        = 32'h8000_0000;
	localparam logic [ANG_W-1:0] ANG_QUARTER     = 32'h4000_0000;
	localparam logic [ANG_W-1:0] ANG_NEG_QUARTER = 32'hC000_0000;

	// atan(2^-i) as a binary angle
	localparam logic [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
	};

	typedef struct packed {
		logic [31:0]        azimuth;
		logic signed [31:0] elevation;
		logic signed [63:0] daz_deast;
		logic signed [63:0] daz_dnorth;
		logic signed [63:0] del_deast;
		logic signed [63:0] del_dnorth;
		logic signed [63:0] del_dup;
		logic               degenerate;
	} res_t;

endpackage

// File: rtl/aewp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aewp_sqrt_cell
// One registered step of a restoring square root: one root bit per cell.
// ----------------------------------------------------------------------------
module aewp_sqrt_cell import aewp_pkg::*; #(
	parameter int RW   = 64,
	parameter int RADW = 64
) (
	input  logic            clk,
	input  logic            en,
	input  logic [RW-1:0]   root_i,
	input  logic [RW+1:0]   rem_i,
	input  logic [RADW-1:0] rad_i,
	output logic [RW-1:0]   root_q,
	output logic [RW+1:0]   rem_q,
	output logic [RADW-1:0] rad_q
);

	logic [RW+3:0] part;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          fits;

	always_comb begin
		part  = {rem_i, rad_i[RADW-1:RADW-2]};
		trial = {2'b00, root_i, 2'b01};
		diff  = part - trial;
		fits  = (part >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= {root_i[RW-2:0], fits};
			rem_q  <= fits ? diff[RW+1:0] : part[RW+1:0];
			rad_q  <= {rad_i[RADW-3:0], 2'b00};
		end
	end

endmodule

// File: rtl/aewp_cordic_cell.sv
// ----------------------------------------------------------------------------
// aewp_cordic_cell
// One registered CORDIC vectoring micro-rotation.
// ----------------------------------------------------------------------------
module aewp_cordic_cell import aewp_pkg::*; #(
	parameter int CW   = 59,
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x_i,
	input  logic signed [CW-1:0] y_i,
	input  logic [ANG_W-1:0]     z_i,
	output logic signed [CW-1:0] x_q,
	output logic signed [CW-1:0] y_q,
	output logic [ANG_W-1:0]     z_q
);

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;

	assign xs = x_i >>> STEP;
	assign ys = y_i >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[CW-1]) begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + ATAN_TAB[STEP];
			end else begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - ATAN_TAB[STEP];
			end
		end
	end

endmodule

// File: rtl/aewp_div_cell.sv
// ----------------------------------------------------------------------------
// aewp_div_cell
// One registered restoring-division step, one quotient bit per lane; the
// lanes share a divisor that travels with them.
// ----------------------------------------------------------------------------
module aewp_div_cell import aewp_pkg::*; #(
	parameter int DW    = 64,
	parameter int LANES = 1
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [DW-1:0]                  den_i,
	input  logic [LANES-1:0][DW-1:0]       rem_i,
	input  logic [LANES-1:0][Q_BITS-1:0]   low_i,
	input  logic [LANES-1:0][Q_BITS-1:0]   q_i,
	output logic [DW-1:0]                  den_q,
	output logic [LANES-1:0][DW-1:0]       rem_q,
	output logic [LANES-1:0][Q_BITS-1:0]   low_q,
	output logic [LANES-1:0][Q_BITS-1:0]   q_q
);

	logic [LANES-1:0][DW:0] part;
	logic [LANES-1:0][DW:0] diff;
	logic [LANES-1:0]       fits;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			part[l] = {rem_i[l], low_i[l][Q_BITS-1]};
			diff[l] = part[l] - {1'b0, den_i};
			fits[l] = (part[l] >= {1'b0, den_i});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_i;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= fits[l] ? diff[l][DW-1:0] : part[l][DW-1:0];
				low_q[l] <= {low_i[l][Q_BITS-2:0], 1'b0};
				q_q[l]   <= {q_i[l][Q_BITS-2:0], fits[l]};
			end
		end
	end

endmodule

// File: rtl/azimuth_elevation_with_partials.sv
// ----------------------------------------------------------------------------
// azimuth_elevation_with_partials
// East/north/up vector to azimuth, elevation and their five partials,
// as one long chain of registered cells.
// ----------------------------------------------------------------------------
//  channel | signals                              | transfer when
//  --------+--------------------------------------+-------------------------
//  in      | in_valid, in_ready, east/north/up    | in_valid & in_ready
//  out     | out_valid, out_ready, 8 result ports | out_valid & out_ready
//
//  One transfer per cycle each way, sustained while out_ready is high.
//  Path from the input transfer to out_valid: the input register loads on
//  the transfer edge, then two front-end stages, COORD_WIDTH + 32
//  square-root cells, one stage that picks up the root, three multiply
//  stages for the elevation divisor, 63 division cells, then the output
//  register.
//  The CORDIC cells run alongside the last CORDIC_STEPS division cells.
//  arst_n clears only the valid bits and the output buffer count.
//  A two-entry output buffer takes results while out_ready is low; the
//  whole chain holds only when both entries are full.
// ----------------------------------------------------------------------------
module azimuth_elevation_with_partials import aewp_pkg::*; #(
	parameter int COORD_WIDTH  = 32,
	parameter int CORDIC_STEPS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        east,
	input  logic [31:0]        north,
	input  logic [31:0]        up,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        azimuth,
	output logic signed [31:0] elevation,
	output logic signed [63:0] daz_deast,
	output logic signed [63:0] daz_dnorth,
	output logic signed [63:0] del_deast,
	output logic signed [63:0] del_dnorth,
	output logic signed [63:0] del_dup,
	output logic               degenerate
);

	localparam int W      = COORD_WIDTH;
	localparam int RW     = W + 32;            // root width, 32 fraction bits
	localparam int RADW   = 2 * W;             // rho^2 and |s|^2 width
	localparam int DELW   = RW + RADW;         // R * |s|^2 width
	localparam int CW     = W + GUARD_SHIFT + 3;
	localparam int CS     = CORDIC_STEPS;
	localparam int SQ_END = 3 + RW;            // stage holding the root
	localparam int DIV0   = SQ_END + 3;        // stage holding the divisors
	localparam int NSTG   = DIV0 + Q_BITS + 1;
	localparam int CST    = NSTG - 1 - CS;     // stage feeding the CORDIC cells
	localparam int RLO    = RW / 2;
	localparam int RHI    = RW - RLO;

	typedef struct packed {
		logic signed [W-1:0] e;
		logic signed [W-1:0] n;
		logic signed [W-1:0] u;
		logic [W-1:0]        ae;
		logic [W-1:0]        an;
		logic [W-1:0]        au;
		logic                degen;
		logic [RADW-1:0]     rho2;
		logic [RADW-1:0]     n2;
		logic [RADW-1:0]     usq;
		logic [RADW-1:0]     peu;
		logic [RADW-1:0]     pnu;
		logic [RW-1:0]       root;
	} ctx_t;

	logic             adv;
	logic [NSTG-1:0]  vld_q;
	ctx_t             ctx_q [NSTG];
	ctx_t             ctx_in;
	ctx_t             ctx_sq;
	ctx_t             ctx_sum;
	ctx_t             ctx_rt;

	// chain handshake: advance unless the output buffer is full
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	// ---------------- front end: magnitudes, squares, sums ----------------
	always_comb begin
		ctx_in       = '0;
		ctx_in.e     = east[W-1:0];
		ctx_in.n     = north[W-1:0];
		ctx_in.u     = up[W-1:0];
		ctx_in.ae    = east[W-1]  ? (~east[W-1:0]  + W'(1)) : east[W-1:0];
		ctx_in.an    = north[W-1] ? (~north[W-1:0] + W'(1)) : north[W-1:0];
		ctx_in.au    = up[W-1]    ? (~up[W-1:0]    + W'(1)) : up[W-1:0];
		ctx_in.degen = (east[W-1:0] == '0) && (north[W-1:0] == '0);
	end

	always_comb begin
		ctx_sq      = ctx_q[0];
		ctx_sq.rho2 = RADW'(ctx_q[0].ae) * RADW'(ctx_q[0].ae);
		ctx_sq.n2   = RADW'(ctx_q[0].an) * RADW'(ctx_q[0].an);
		ctx_sq.usq  = RADW'(ctx_q[0].au) * RADW'(ctx_q[0].au);
		ctx_sq.peu  = RADW'(ctx_q[0].ae) * RADW'(ctx_q[0].au);
		ctx_sq.pnu  = RADW'(ctx_q[0].an) * RADW'(ctx_q[0].au);
	end

	always_comb begin
		ctx_sum      = ctx_q[1];
		ctx_sum.rho2 = ctx_q[1].rho2 + ctx_q[1].n2;
		ctx_sum.n2   = ctx_q[1].rho2 + ctx_q[1].n2 + ctx_q[1].usq;
	end

	// root of the square-root chain
	logic [RW-1:0]   sq_root [0:RW];
	logic [RW+1:0]   sq_rem  [0:RW];
	logic [RADW-1:0] sq_rad  [0:RW];

	// the last square-root cell lines up with the stage just before SQ_END
	always_comb begin
		ctx_rt      = ctx_q[SQ_END-1];
		ctx_rt.root = sq_root[RW];
	end

	// context line follows every item down the chain
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_q[0] <= ctx_in;
			ctx_q[1] <= ctx_sq;
			ctx_q[2] <= ctx_sum;
			for (int s = 3; s < NSTG; s++) begin
				if (s == SQ_END) begin
					ctx_q[s] <= ctx_rt;
				end else begin
					ctx_q[s] <= ctx_q[s-1];
				end
			end
		end
	end

	// ---------------- square root: R = floor(sqrt(rho2 * 2^64)) ----------
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;
	assign sq_rad[0]  = ctx_q[2].rho2;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		aewp_sqrt_cell #(.RW(RW), .RADW(RADW)) u_cell (
			.clk    (clk),
			.en     (adv),
			.root_i (sq_root[k]),
			.rem_i  (sq_rem[k]),
			.rad_i  (sq_rad[k]),
			.root_q (sq_root[k+1]),
			.rem_q  (sq_rem[k+1]),
			.rad_q  (sq_rad[k+1])
		);
	end

	// ---------------- divisor R * |s|^2, split over three stages ---------
	logic [RLO+W-1:0]    mul_ll_s1;
	logic [RLO+W-1:0]    mul_lh_s1;
	logic [RHI+W-1:0]    mul_hl_s1;
	logic [RHI+W-1:0]    mul_hh_s1;
	logic [RLO+RADW-1:0] acc_l_s2;
	logic [RHI+RADW-1:0] acc_h_s2;
	logic [DELW-1:0]     den_del_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_ll_s1  <= (RLO+W)'(ctx_q[SQ_END].root[RLO-1:0])
				* (RLO+W)'(ctx_q[SQ_END].n2[W-1:0]);
			mul_lh_s1  <= (RLO+W)'(ctx_q[SQ_END].root[RLO-1:0])
				* (RLO+W)'(ctx_q[SQ_END].n2[RADW-1:W]);
			mul_hl_s1  <= (RHI+W)'(ctx_q[SQ_END].root[RW-1:RLO])
				* (RHI+W)'(ctx_q[SQ_END].n2[W-1:0]);
			mul_hh_s1  <= (RHI+W)'(ctx_q[SQ_END].root[RW-1:RLO])
				* (RHI+W)'(ctx_q[SQ_END].n2[RADW-1:W]);
			acc_l_s2   <= (RLO+RADW)'(mul_ll_s1) + ((RLO+RADW)'(mul_lh_s1) << W);
			acc_h_s2   <= (RHI+RADW)'(mul_hl_s1) + ((RHI+RADW)'(mul_hh_s1) << W);
			den_del_s3 <= DELW'(acc_l_s2) + (DELW'(acc_h_s2) << RLO);
		end
	end

	// ---------------- division chains ------------------------------------
	// lane 0: |north|, lane 1: |east|, over rho2
	logic [RADW-1:0]                   dz_den [0:Q_BITS];
	logic [1:0][RADW-1:0]              dz_rem [0:Q_BITS];
	logic [1:0][Q_BITS-1:0]            dz_low [0:Q_BITS];
	logic [1:0][Q_BITS-1:0]            dz_q   [0:Q_BITS];
	// lane 0: |e*u|, lane 1: |n*u|, over R*|s|^2
	logic [DELW-1:0]                   dl_den [0:Q_BITS];
	logic [1:0][DELW-1:0]              dl_rem [0:Q_BITS];
	logic [1:0][Q_BITS-1:0]            dl_low [0:Q_BITS];
	logic [1:0][Q_BITS-1:0]            dl_q   [0:Q_BITS];
	// R * 2^30 over |s|^2
	logic [RADW-1:0]                   du_den [0:Q_BITS];
	logic [0:0][RADW-1:0]              du_rem [0:Q_BITS];
	logic [0:0][Q_BITS-1:0]            du_low [0:Q_BITS];
	logic [0:0][Q_BITS-1:0]            du_q   [0:Q_BITS];

	// numerators enter as (num >> 63) with the low 63 bits shifted in later
	always_comb begin
		dz_den[0]    = ctx_q[DIV0].rho2;
		dz_rem[0][0] = RADW'(ctx_q[DIV0].an >> 1);
		dz_rem[0][1] = RADW'(ctx_q[DIV0].ae >> 1);
		dz_low[0][0] = {ctx_q[DIV0].an[0], {(Q_BITS-1){1'b0}}};
		dz_low[0][1] = {ctx_q[DIV0].ae[0], {(Q_BITS-1){1'b0}}};
		dz_q[0]      = '0;

		dl_den[0]    = den_del_s3;
		dl_rem[0][0] = DELW'(ctx_q[DIV0].peu) << (DEL_NUM_SHIFT - Q_BITS);
		dl_rem[0][1] = DELW'(ctx_q[DIV0].pnu) << (DEL_NUM_SHIFT - Q_BITS);
		dl_low[0]    = '0;
		dl_q[0]      = '0;

		du_den[0]    = ctx_q[DIV0].n2;
		du_rem[0][0] = RADW'(ctx_q[DIV0].root >> (Q_BITS - DUP_SHIFT));
		du_low[0][0] = Q_BITS'({ctx_q[DIV0].root, {DUP_SHIFT{1'b0}}});
		du_q[0]      = '0;
	end

	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		aewp_div_cell #(.DW(RADW), .LANES(2)) u_daz (
			.clk   (clk),
			.en    (adv),
			.den_i (dz_den[j]),
			.rem_i (dz_rem[j]),
			.low_i (dz_low[j]),
			.q_i   (dz_q[j]),
			.den_q (dz_den[j+1]),
			.rem_q (dz_rem[j+1]),
			.low_q (dz_low[j+1]),
			.q_q   (dz_q[j+1])
		);
		aewp_div_cell #(.DW(DELW), .LANES(2)) u_del (
			.clk   (clk),
			.en    (adv),
			.den_i (dl_den[j]),
			.rem_i (dl_rem[j]),
			.low_i (dl_low[j]),
			.q_i   (dl_q[j]),
			.den_q (dl_den[j+1]),
			.rem_q (dl_rem[j+1]),
			.low_q (dl_low[j+1]),
			.q_q   (dl_q[j+1])
		);
		aewp_div_cell #(.DW(RADW), .LANES(1)) u_dup (
			.clk   (clk),
			.en    (adv),
			.den_i (du_den[j]),
			.rem_i (du_rem[j]),
			.low_i (du_low[j]),
			.q_i   (du_q[j]),
			.den_q (du_den[j+1]),
			.rem_q (du_rem[j+1]),
			.low_q (du_low[j+1]),
			.q_q   (du_q[j+1])
		);
	end

	// ---------------- CORDIC: azimuth and elevation ----------------------
	logic signed [CW-1:0] az_x [0:CS];
	logic signed [CW-1:0] az_y [0:CS];
	logic [ANG_W-1:0]     az_z [0:CS];
	logic signed [CW-1:0] el_x [0:CS];
	logic signed [CW-1:0] el_y [0:CS];
	logic [ANG_W-1:0]     el_z [0:CS];
	logic signed [CW-1:0] n_sc;
	logic signed [CW-1:0] e_sc;

	always_comb begin
		n_sc = $signed({{(CW-W-GUARD_SHIFT){ctx_q[CST].n[W-1]}}, ctx_q[CST].n,
			{GUARD_SHIFT{1'b0}}});
		e_sc = $signed({{(CW-W-GUARD_SHIFT){ctx_q[CST].e[W-1]}}, ctx_q[CST].e,
			{GUARD_SHIFT{1'b0}}});
		// left half plane: rotate by pi first
		if (n_sc[CW-1]) begin
			az_x[0] = -n_sc;
			az_y[0] = -e_sc;
			az_z[0] = ANG_HALF;
		end else begin
			az_x[0] = n_sc;
			az_y[0] = e_sc;
			az_z[0] = '0;
		end
		el_x[0] = $signed({{(CW-RW+8){1'b0}}, ctx_q[CST].root[RW-1:8]});
		el_y[0] = $signed({{(CW-W-GUARD_SHIFT){ctx_q[CST].u[W-1]}}, ctx_q[CST].u,
			{GUARD_SHIFT{1'b0}}});
		el_z[0] = '0;
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		aewp_cordic_cell #(.CW(CW), .STEP(i)) u_az (
			.clk (clk),
			.en  (adv),
			.x_i (az_x[i]),
			.y_i (az_y[i]),
			.z_i (az_z[i]),
			.x_q (az_x[i+1]),
			.y_q (az_y[i+1]),
			.z_q (az_z[i+1])
		);
		aewp_cordic_cell #(.CW(CW), .STEP(i)) u_el (
			.clk (clk),
			.en  (adv),
			.x_i (el_x[i]),
			.y_i (el_y[i]),
			.z_i (el_z[i]),
			.x_q (el_x[i+1]),
			.y_q (el_y[i+1]),
			.z_q (el_z[i+1])
		);
	end

	// ---------------- result assembly ------------------------------------
	function automatic logic signed [63:0] apply_sign(input logic neg,
		input logic [Q_BITS-1:0] m);
		logic [63:0] w;
		w = 64'(m);
		return neg ? -$signed(w) : $signed(w);
	endfunction

	ctx_t fin;
	res_t res;

	assign fin = ctx_q[NSTG-1];

	always_comb begin
		res            = '0;
		res.degenerate = fin.degen;
		if (fin.degen) begin
			// azimuth and partials stay zero; elevation is the sign of up times pi/2
			if (fin.u > 0) begin
				res.elevation = ANG_QUARTER;
			end else if (fin.u < 0) begin
				res.elevation = ANG_NEG_QUARTER;
			end
		end else begin
			res.azimuth = az_z[CS];
			// clamp CORDIC overshoot past +-pi/2
			priority if (!el_z[CS][ANG_W-1] && el_z[CS] > ANG_QUARTER) begin
				res.elevation = ANG_QUARTER;
			end else if (el_z[CS][ANG_W-1] && el_z[CS] < ANG_NEG_QUARTER) begin
				res.elevation = ANG_NEG_QUARTER;
			end else begin
				res.elevation = el_z[CS];
			end
			res.daz_deast  = apply_sign(fin.n[W-1], dz_q[Q_BITS][0]);
			res.daz_dnorth = apply_sign(fin.e > 0, dz_q[Q_BITS][1]);
			res.del_deast  = apply_sign(fin.e[W-1] == fin.u[W-1], dl_q[Q_BITS][0]);
			res.del_dnorth = apply_sign(fin.n[W-1] == fin.u[W-1], dl_q[Q_BITS][1]);
			res.del_dup    = apply_sign(1'b0, du_q[Q_BITS][0]);
		end
	end

	// ---------------- two-entry output buffer ----------------------------
	logic [1:0] cnt_q;
	res_t       head_q;
	res_t       spare_q;
	logic       push;
	logic       pop;

	assign adv       = (cnt_q != 2'd2);
	assign push      = adv && vld_q[NSTG-1];
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || pop)) begin
			head_q <= res;
		end else if (pop && cnt_q == 2'd2) begin
			head_q <= spare_q;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			spare_q <= res;
		end
	end

	assign azimuth    = head_q.azimuth;
	assign elevation  = head_q.elevation;
	assign daz_deast  = head_q.daz_deast;
	assign daz_dnorth = head_q.daz_dnorth;
	assign del_deast  = head_q.del_deast;
	assign del_dnorth = head_q.del_dnorth;
	assign del_dup    = head_q.del_dup;
	assign degenerate = head_q.degenerate;

endmodule

// File: rtl/aewp_checker.sv
// ----------------------------------------------------------------------------
// aewp_checker
// Port-level checks on the azimuth / elevation results, bound to the top.
// ----------------------------------------------------------------------------
module aewp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [31:0]        azimuth,
	input logic signed [31:0] elevation,
	input logic signed [63:0] daz_deast,
	input logic signed [63:0] daz_dnorth,
	input logic signed [63:0] del_deast,
	input logic signed [63:0] del_dnorth,
	input logic signed [63:0] del_dup,
	input logic               degenerate
);

	// a degenerate vector has no azimuth and no partials
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> azimuth == 32'd0 && daz_deast == 64'sd0
		&& daz_dnorth == 64'sd0 && del_deast == 64'sd0 && del_dnorth == 64'sd0
		&& del_dup == 64'sd0)
		else $error("degenerate result carries nonzero angle or partial");

	a_degen_el: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> elevation == 32'sh4000_0000
		|| elevation == -32'sh4000_0000 || elevation == 32'sd0)
		else $error("degenerate elevation is not zero or a pole");

	a_el_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> elevation <= 32'sh4000_0000 && elevation >= -32'sh4000_0000)
		else $error("elevation outside +-pi/2");

	a_dup_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> !del_dup[63])
		else $error("d(el)/d(up) negative");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(azimuth) && $stable(del_dup))
		else $error("result dropped or changed while stalled");

endmodule

bind azimuth_elevation_with_partials aewp_checker u_aewp_checker (.*);
